@@ hw/rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/nrmq_pkg.sv @@
`timescale 1ns / 1ps

package nrmq_pkg;

  localparam int CMD_W    = 2;
  localparam int NUC_W    = 2;
  localparam int IDX_W    = 10;
  localparam int FACTOR_W = 3;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  localparam logic [NUC_W-1:0] NUC_A = 2'd0;
  localparam logic [NUC_W-1:0] NUC_C = 2'd1;
  localparam logic [NUC_W-1:0] NUC_G = 2'd2;

  localparam logic [FACTOR_W-1:0] FACTOR_A = 3'd1;
  localparam logic [FACTOR_W-1:0] FACTOR_C = 3'd2;
  localparam logic [FACTOR_W-1:0] FACTOR_G = 3'd3;
  localparam logic [FACTOR_W-1:0] FACTOR_T = 3'd4;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  typedef struct packed {
    logic clear;
    logic append;
    logic rd_lo;
    logic rd_hi;
    logic finish;
  } nrmq_ctl_t;

endpackage

@@ hw/rtl/nucleotide_range_min_query_top.sv @@
`timescale 1ns / 1ps
// Nucleotide range minimum query.
// Input channel (in_valid / in_stall): in_cmd 0 clears the sequence, 1 appends
// in_nucleotide (A=0 C=1 G=2 T=3), 2 queries [in_start_index, in_end_index].
// Result channel (out_valid / out_stall): one item per query, carrying the
// smallest impact factor in the range (1 A .. 4 T) and a status bit; an empty
// or out-of-sequence range returns status 1 with factor 4.
// Clear and append give no result; an append to a full sequence (MAX_LEN
// entries) is dropped.
// A query makes two reads of the single-port prefix-count memory (entry
// start, then entry end+1) and then a compare cycle; the result is registered
// and shows in the cycle after the compare. No new item is taken until the
// compare cycle completes.
// If the receiver stalls, the result holds in the output register. Appends
// and clears are still taken, but a further query stops in its compare cycle,
// with the input stalled, until that register frees up.
// Reset (rst_n low, synchronous) empties the sequence and drops any result.
// No clearing pass is needed after reset.
module nucleotide_range_min_query_top #(
  parameter int MAX_LEN = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [nrmq_pkg::CMD_W-1:0]      in_cmd,
  input  logic [nrmq_pkg::NUC_W-1:0]      in_nucleotide,
  input  logic [nrmq_pkg::IDX_W-1:0]      in_start_index,
  input  logic [nrmq_pkg::IDX_W-1:0]      in_end_index,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [nrmq_pkg::FACTOR_W-1:0]   out_min_factor,
  output logic                            out_status
);
  import nrmq_pkg::*;

  nrmq_ctl_t ctl;
  logic      out_free;

  nrmq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .out_free (out_free),
    .in_stall (in_stall),
    .ctl      (ctl)
  );

  nrmq_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .in_nucleotide  (in_nucleotide),
    .in_start_index (in_start_index),
    .in_end_index   (in_end_index),
    .out_stall      (out_stall),
    .out_free       (out_free),
    .out_valid      (out_valid),
    .out_min_factor (out_min_factor),
    .out_status     (out_status)
  );

  `include "assert_macros.svh"

  `ASSERT_NEXT(a_finish_shows, clk, rst_n, ctl.finish, out_valid)
  `ASSERT_NEXT(a_lo_then_hi, clk, rst_n, ctl.rd_lo, ctl.rd_hi && in_stall)
  `ASSERT_IMP(a_bad_is_t, clk, rst_n, out_valid && (out_status == STATUS_BAD), out_min_factor == FACTOR_T)
  `ASSERT_IMP(a_one_op, clk, rst_n, 1'b1, $onehot0({ctl.clear, ctl.append, ctl.rd_lo, ctl.rd_hi, ctl.finish}))

endmodule

@@ hw/rtl/nrmq_ctrl.sv @@
`timescale 1ns / 1ps

module nrmq_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [nrmq_pkg::CMD_W-1:0]  in_cmd,
  input  logic                        out_free,
  output logic                        in_stall,
  output nrmq_pkg::nrmq_ctl_t         ctl
);
  import nrmq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RD_HI = 3'b010,
    ST_FIN   = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    ctl        = '0;
    ctl.clear  = accept && (in_cmd == CMD_CLEAR);
    ctl.append = accept && (in_cmd == CMD_APPEND);
    ctl.rd_lo  = accept && (in_cmd == CMD_QUERY);
    ctl.rd_hi  = (state_r == ST_RD_HI);
    ctl.finish = (state_r == ST_FIN) && out_free;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (ctl.rd_lo) state_nxt = ST_RD_HI;
      end
      ST_RD_HI: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hw/rtl/nrmq_dp.sv @@
`timescale 1ns / 1ps

module nrmq_dp #(
  parameter int MAX_LEN = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  nrmq_pkg::nrmq_ctl_t             ctl,
  input  logic [nrmq_pkg::NUC_W-1:0]      in_nucleotide,
  input  logic [nrmq_pkg::IDX_W-1:0]      in_start_index,
  input  logic [nrmq_pkg::IDX_W-1:0]      in_end_index,
  input  logic                            out_stall,
  output logic                            out_free,
  output logic                            out_valid,
  output logic [nrmq_pkg::FACTOR_W-1:0]   out_min_factor,
  output logic                            out_status
);
  import nrmq_pkg::*;

  localparam int AW    = $clog2(MAX_LEN + 1);
  localparam int DEPTH = MAX_LEN + 1;
  localparam int CMP_W = (AW > IDX_W + 1) ? AW : IDX_W + 1;
  localparam int EW    = 3 * AW;

  logic [AW-1:0]    seq_len_r, seq_len_nxt;
  logic [AW-1:0]    cnt_a_r, cnt_c_r, cnt_g_r;
  logic [AW-1:0]    cnt_a_nxt, cnt_c_nxt, cnt_g_nxt;
  logic [EW-1:0]    mem [DEPTH];
  logic [EW-1:0]    rd_q_r, rd_eff, lo_q_r;
  logic             rd_zero_r;
  logic [IDX_W-1:0] hi_idx_r;
  logic             bad_r, bad_now, full;
  logic             out_valid_r, out_status_r;
  logic [FACTOR_W-1:0] out_factor_r, factor;
  logic [CMP_W-1:0] lo_ext, hi_ext, len_ext, hi_plus;
  logic [AW-1:0]    rd_addr;
  logic             rd_en, wr_en;

  assign full    = (seq_len_r == AW'(MAX_LEN));
  assign lo_ext  = CMP_W'(in_start_index);
  assign hi_ext  = CMP_W'(in_end_index);
  assign len_ext = CMP_W'(seq_len_r);
  assign bad_now = (lo_ext > hi_ext) || (hi_ext >= len_ext);
  assign hi_plus = CMP_W'(hi_idx_r) + CMP_W'(1);

  assign cnt_a_nxt = cnt_a_r + {{(AW-1){1'b0}}, (in_nucleotide == NUC_A)};
  assign cnt_c_nxt = cnt_c_r + {{(AW-1){1'b0}}, (in_nucleotide == NUC_C)};
  assign cnt_g_nxt = cnt_g_r + {{(AW-1){1'b0}}, (in_nucleotide == NUC_G)};
  assign seq_len_nxt = seq_len_r + AW'(1);

  assign wr_en   = ctl.append && !full;
  assign rd_en   = (ctl.rd_lo && !bad_now) || (ctl.rd_hi && !bad_r);
  assign rd_addr = ctl.rd_lo ? lo_ext[AW-1:0] : hi_plus[AW-1:0];

  // single port: write on append, reads for a query's start and end+1 entries
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[seq_len_nxt] <= {cnt_a_nxt, cnt_c_nxt, cnt_g_nxt};
    end else if (rd_en) begin
      rd_q_r    <= mem[rd_addr];
      rd_zero_r <= (rd_addr == '0);
    end
  end

  // entry zero is never written and reads as zero
  assign rd_eff = rd_zero_r ? '0 : rd_q_r;

  always_ff @(posedge clk) begin
    if (ctl.rd_lo) begin
      hi_idx_r <= in_end_index;
      bad_r    <= bad_now;
    end
    if (ctl.rd_hi) begin
      lo_q_r <= rd_eff;
    end
  end

  always_comb begin
    if (rd_eff[EW-1:2*AW] != lo_q_r[EW-1:2*AW]) begin
      factor = FACTOR_A;
    end else if (rd_eff[2*AW-1:AW] != lo_q_r[2*AW-1:AW]) begin
      factor = FACTOR_C;
    end else if (rd_eff[AW-1:0] != lo_q_r[AW-1:0]) begin
      factor = FACTOR_G;
    end else begin
      factor = FACTOR_T;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_len_r <= '0;
      cnt_a_r   <= '0;
      cnt_c_r   <= '0;
      cnt_g_r   <= '0;
    end else if (ctl.clear) begin
      seq_len_r <= '0;
      cnt_a_r   <= '0;
      cnt_c_r   <= '0;
      cnt_g_r   <= '0;
    end else if (wr_en) begin
      seq_len_r <= seq_len_nxt;
      cnt_a_r   <= cnt_a_nxt;
      cnt_c_r   <= cnt_c_nxt;
      cnt_g_r   <= cnt_g_nxt;
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      out_factor_r <= bad_r ? FACTOR_T : factor;
      out_status_r <= bad_r ? STATUS_BAD : STATUS_OK;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_min_factor = out_factor_r;
  assign out_status     = out_status_r;

endmodule

@@ tb/nucleotide_range_min_query_top_tb.sv @@
`timescale 1ns / 1ps

module nucleotide_range_min_query_top_tb;
  import nrmq_pkg::*;

  localparam int MAX_LEN = 1024;
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
  localparam logic [NUC_W-1:0] NUC_T = 2'd3;
  localparam int ITEM_TARGET = 1100;
  localparam int GAP_MAX = 18;
  localparam int LONG_HOLD = 200;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [FACTOR_W-1:0] factor;
    logic                status;
  } answer_t;

  class min_factor_scoreboard;
    logic [10:0] cnt_a [MAX_LEN+1];
    logic [10:0] cnt_c [MAX_LEN+1];
    logic [10:0] cnt_g [MAX_LEN+1];
    logic [10:0] run_a, run_c, run_g;
    int unsigned seq_len;
    answer_t     answers_q[$];
    int          errors, checked, dropped, bad_ranges;

    function new();
      foreach (cnt_a[i]) begin
        cnt_a[i] = '0;
        cnt_c[i] = '0;
        cnt_g[i] = '0;
      end
      run_a = '0;
      run_c = '0;
      run_g = '0;
      seq_len = 0;
      errors = 0;
      checked = 0;
      dropped = 0;
      bad_ranges = 0;
    endfunction

    function int pending();
      return answers_q.size();
    endfunction

    function void note_item(logic [CMD_W-1:0] cmd, logic [NUC_W-1:0] nuc,
                            logic [IDX_W-1:0] lo, logic [IDX_W-1:0] hi);
      answer_t ans;
      int      top;
      case (cmd)
        CMD_CLEAR: begin
          seq_len = 0;
          run_a = '0;
          run_c = '0;
          run_g = '0;
        end
        CMD_APPEND: begin
          if (seq_len >= MAX_LEN) begin
            dropped++;
          end else begin
            if (nuc == NUC_A) run_a++;
            else if (nuc == NUC_C) run_c++;
            else if (nuc == NUC_G) run_g++;
            seq_len++;
            cnt_a[seq_len] = run_a;
            cnt_c[seq_len] = run_c;
            cnt_g[seq_len] = run_g;
          end
        end
        CMD_QUERY: begin
          if (lo <= hi && hi < seq_len) begin
            top = int'(hi) + 1;
            ans.status = STATUS_OK;
            if (cnt_a[top] != cnt_a[lo]) ans.factor = FACTOR_A;
            else if (cnt_c[top] != cnt_c[lo]) ans.factor = FACTOR_C;
            else if (cnt_g[top] != cnt_g[lo]) ans.factor = FACTOR_G;
            else ans.factor = FACTOR_T;
          end else begin
            ans.factor = FACTOR_T;
            ans.status = STATUS_BAD;
            bad_ranges++;
          end
          answers_q = {answers_q, ans};
        end
        default: ;
      endcase
    endfunction

    function void check(logic [FACTOR_W-1:0] factor, logic status);
      answer_t ans;
      checked++;
      if (answers_q.size() == 0) begin
        errors++;
        $display("%0t: result with no query pending: expected none, actual factor %0d status %0d",
                 $time, factor, status);
        return;
      end
      ans = answers_q.pop_front();
      if (factor !== ans.factor) begin
        errors++;
        $display("%0t: min_factor mismatch: expected %0d, actual %0d",
                 $time, ans.factor, factor);
      end
      if (status !== ans.status) begin
        errors++;
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, ans.status, status);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [CMD_W-1:0]    in_cmd = CMD_NOP;
  logic [NUC_W-1:0]    in_nucleotide = '0;
  logic [IDX_W-1:0]    in_start_index = '0;
  logic [IDX_W-1:0]    in_end_index = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [FACTOR_W-1:0] out_min_factor;
  logic                out_status;

  min_factor_scoreboard sb = new();
  int n_items = 0;
  int send_gap_max = GAP_MAX;
  int rcv_gap_max = GAP_MAX;
  bit hold_req = 1'b0;
  bit hold_active = 1'b0;

  nucleotide_range_min_query_top #(.MAX_LEN(MAX_LEN)) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_nucleotide (in_nucleotide),
    .in_start_index(in_start_index),
    .in_end_index  (in_end_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_min_factor(out_min_factor),
    .out_status    (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check(out_min_factor, out_status);
  end

  // result side: per-item stall, one long hold on request
  initial begin : receiver
    int w;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_active = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_active = 1'b0;
      end else begin
        w = (rcv_gap_max == 0) ? 0 : $urandom_range(0, rcv_gap_max);
        if (w > 0) begin
          out_stall <= 1'b1;
          repeat (w) @(negedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid && !hold_req);
      if ($urandom_range(0, 39) == 0) rcv_gap_max = (rcv_gap_max == 0) ? GAP_MAX : 0;
    end
  end

  function automatic logic [IDX_W-1:0] rand_idx();
    return IDX_W'($urandom());
  endfunction

  // mostly nucleotides at or above floor, now and then any
  function automatic logic [NUC_W-1:0] pick_nuc(int floor);
    if ($urandom_range(0, 15) == 0) return NUC_W'($urandom_range(0, 3));
    return NUC_W'($urandom_range(floor, 3));
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [NUC_W-1:0] nuc,
                           input logic [IDX_W-1:0] lo, input logic [IDX_W-1:0] hi);
    int gap;
    gap = (send_gap_max == 0) ? 0 : $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_nucleotide <= nuc;
    in_start_index <= lo;
    in_end_index <= hi;
    do @(posedge clk); while (in_stall);
    sb.note_item(cmd, nuc, lo, hi);
    if (cmd != CMD_NOP) n_items++;
    @(negedge clk);
  endtask

  task automatic send_append(input logic [NUC_W-1:0] nuc);
    send_item(CMD_APPEND, nuc, rand_idx(), rand_idx());
  endtask

  task automatic send_query(input int lo, input int hi);
    send_item(CMD_QUERY, NUC_W'($urandom()), IDX_W'(lo), IDX_W'(hi));
  endtask

  task automatic send_clear();
    send_item(CMD_CLEAR, NUC_W'($urandom()), rand_idx(), rand_idx());
  endtask

  task automatic append_run(input int n, input int floor);
    repeat (n) send_append(pick_nuc(floor));
  endtask

  // mostly short ranges inside the sequence, the rest anywhere
  task automatic random_query();
    int unsigned len, lo, hi, lim;
    len = sb.seq_len;
    if (len > 0 && $urandom_range(0, 4) != 0) begin
      lo = $urandom_range(0, len - 1);
      lim = len - 1 - lo;
      if ($urandom_range(0, 3) != 0 && lim > 7) lim = 7;
      hi = lo + $urandom_range(0, lim);
    end else begin
      lo = $urandom_range(0, 1023);
      hi = $urandom_range(0, 1023);
    end
    send_query(lo, hi);
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  initial begin
    #5000000;
    $display("Timeout with %0d results outstanding", sb.pending());
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_item(CMD_NOP, NUC_T, 10'h3ff, 10'h3ff);
    send_append(NUC_A);
    send_append(NUC_C);
    send_append(NUC_G);
    send_append(NUC_T);
    send_append(NUC_T);
    send_append(NUC_G);
    send_query(0, 5);
    send_query(1, 5);
    send_query(2, 5);
    send_query(3, 4);
    send_query(5, 5);
    send_query(3, 3);
    send_query(0, 0);
    send_query(4, 2);
    // stale entries past the new length stay behind after a clear
    send_clear();
    send_append(NUC_T);
    send_append(NUC_C);
    send_append(NUC_T);
    send_query(0, 2);
    send_query(2, 2);
    send_query(1, 3);
    send_query(2, 4);

    // fill to full length, then a few appends that get dropped
    send_clear();
    append_run(MAX_LEN + 4, 2);
    send_query(1023, 1023);
    send_query(0, 1023);
    send_query(1023, 0);

    // receiver holds off while queries keep coming
    hold_req = 1'b1;
    in_valid <= 1'b0;
    @(negedge clk);
    while (!hold_active) @(negedge clk);
    send_gap_max = 0;
    repeat (12) random_query();
    send_gap_max = GAP_MAX;
    pause_until_drained();
    send_clear();
    send_query(0, 0);

    while (n_items < ITEM_TARGET) begin
      send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
      if (sb.seq_len > MAX_LEN - 40 || $urandom_range(0, 3) != 0) begin
        send_clear();
        if ($urandom_range(0, 7) == 0) send_query(0, 0);
      end
      append_run($urandom_range(1, 40), $urandom_range(0, 3));
      if ($urandom_range(0, 5) == 0) send_item(CMD_NOP, NUC_W'($urandom()), rand_idx(), rand_idx());
      repeat ($urandom_range(1, 12)) random_query();
      if ($urandom_range(0, 5) == 0) pause_until_drained();
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d items (clears, appends incl. %0d dropped at full length, queries).",
             n_items, sb.dropped);
    $display("Checked %0d results, %0d of them empty or out-of-sequence ranges.",
             sb.checked, sb.bad_ranges);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
